// ===== rtl/cie_pkg.sv =====
// shared types, character codes and helpers for the css identifier escaper
package cie_pkg;

  localparam int QDEPTH = 2;
  localparam int QAW = $clog2(QDEPTH);
  localparam int QCW = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CTRL_MAX = 8'h1F;
  localparam logic [7:0] LEAD_MIN = 8'hC2;
  localparam logic [7:0] REPL_0   = 8'hEF;
  localparam logic [7:0] REPL_1   = 8'hBF;
  localparam logic [7:0] REPL_2   = 8'hBD;

  typedef enum logic [1:0] {
    OP_RAW  = 2'd0,
    OP_HEX  = 2'd1,
    OP_REPL = 2'd2,
    OP_BSL  = 2'd3
  } op_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_beat_t;

  typedef struct packed {
    op_t             op;
    logic [3:0][7:0] bytes;
    logic [2:0]      len;
    logic            last;
  } cmd_t;

  function automatic logic [7:0] hex_char(logic [3:0] v);
    return (v < 4'd10) ? (8'h30 + {4'b0, v}) : (8'h57 + {4'b0, v});
  endfunction

endpackage

// ===== rtl/cie_front.sv =====
// front end: utf-8 gathering, character classification, command generation
module cie_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  cie_pkg::in_beat_t item,
  input  logic              q_full,
  output logic              q_push,
  output cie_pkg::cmd_t     q_cmd
);
  import cie_pkg::*;

  logic [7:0] pend0, pend1, pend2;
  logic [1:0] pcount, pcount_next;
  logic [2:0] seqlen, seqlen_next;
  logic [1:0] cpos, cpos_next;
  logic       fdash, fdash_next;

  logic [7:0]      b;
  logic            lst;
  logic            accept;
  logic            emit;
  logic [20:0]     cp_m;
  logic [3:0][7:0] raw;
  logic            complete;
  logic            wr_pend;
  logic            start_seq;
  cmd_t            cmd;

  function automatic cmd_t char_cmd(logic [20:0] cp, logic [1:0] pos, logic fd,
                                    logic alone, logic [3:0][7:0] rb,
                                    logic [2:0] nb, logic lt);
    cmd_t c;
    logic dig;
    logic name;
    c = '0;
    c.last = lt;
    dig = (cp >= 21'h30) && (cp <= 21'h39);
    name = (cp >= 21'h80) || (cp == 21'(CH_DASH)) || (cp == 21'(CH_UNDER)) || dig ||
           ((cp >= 21'h41) && (cp <= 21'h5A)) || ((cp >= 21'h61) && (cp <= 21'h7A));
    priority if (cp == 21'd0) begin
      c.op = OP_REPL;
      c.len = 3'd3;
    end else if ((cp <= 21'(CTRL_MAX)) || (cp == 21'(CH_DEL)) || (pos == 2'd0 && dig) ||
                 (pos == 2'd1 && dig && fd)) begin
      c.op = OP_HEX;
      c.bytes[0] = cp[7:0];
      c.len = (cp >= 21'd16) ? 3'd4 : 3'd3;
    end else if (pos == 2'd0 && cp == 21'(CH_DASH) && alone) begin
      c.op = OP_BSL;
      c.bytes[0] = CH_DASH;
      c.len = 3'd2;
    end else if (name) begin
      c.op = OP_RAW;
      c.bytes = rb;
      c.len = nb;
    end else begin
      c.op = OP_BSL;
      c.bytes[0] = {1'b0, cp[6:0]};
      c.len = 3'd2;
    end
    return c;
  endfunction

  assign b = item.in_byte;
  assign lst = item.in_last;
  assign accept = push && !q_full;

  always_comb begin
    unique case (seqlen)
      3'd2:    cp_m = {10'b0, pend0[4:0], b[5:0]};
      3'd3:    cp_m = {5'b0, pend0[3:0], pend1[5:0], b[5:0]};
      default: cp_m = {pend0[2:0], pend1[5:0], pend2[5:0], b[5:0]};
    endcase
    raw[0] = (pcount == 2'd0) ? b : pend0;
    raw[1] = (pcount == 2'd1) ? b : pend1;
    raw[2] = (pcount == 2'd2) ? b : pend2;
    raw[3] = b;
    complete = ({1'b0, pcount} + 3'd1) >= seqlen;
  end

  always_comb begin
    emit = 1'b0;
    cmd = '0;
    wr_pend = 1'b0;
    start_seq = 1'b0;
    pcount_next = pcount;
    seqlen_next = seqlen;
    cpos_next = cpos;
    fdash_next = fdash;
    if (seqlen != 3'd0) begin
      if (complete) begin
        emit = 1'b1;
        cmd = char_cmd(cp_m, cpos, fdash, 1'b0, raw, seqlen, lst);
        pcount_next = 2'd0;
        seqlen_next = 3'd0;
        if (cpos == 2'd0) fdash_next = 1'b0;
        if (cpos != 2'd2) cpos_next = cpos + 2'd1;
      end else if (lst) begin
        emit = 1'b1;
        cmd.op = OP_RAW;
        cmd.bytes = raw;
        cmd.len = {1'b0, pcount} + 3'd1;
        cmd.last = 1'b1;
      end else begin
        wr_pend = 1'b1;
        pcount_next = pcount + 2'd1;
      end
    end else if (b < 8'h80) begin
      emit = 1'b1;
      cmd = char_cmd({13'b0, b}, cpos, fdash, lst && (cpos == 2'd0), raw, 3'd1, lst);
      if (cpos == 2'd0) fdash_next = (b == CH_DASH);
      if (cpos != 2'd2) cpos_next = cpos + 2'd1;
    end else if (b < LEAD_MIN || lst) begin
      emit = 1'b1;
      cmd.op = OP_RAW;
      cmd.bytes = raw;
      cmd.len = 3'd1;
      cmd.last = lst;
      if (!lst) begin
        if (cpos == 2'd0) fdash_next = 1'b0;
        if (cpos != 2'd2) cpos_next = cpos + 2'd1;
      end
    end else begin
      start_seq = 1'b1;
      pcount_next = 2'd1;
      seqlen_next = (b < 8'hE0) ? 3'd2 : (b < 8'hF0) ? 3'd3 : 3'd4;
    end
    if (lst) begin
      pcount_next = 2'd0;
      seqlen_next = 3'd0;
      cpos_next = 2'd0;
      fdash_next = 1'b0;
    end
  end

  assign q_push = accept && emit;
  assign q_cmd = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      pcount <= 2'd0;
      seqlen <= 3'd0;
      cpos <= 2'd0;
      fdash <= 1'b0;
    end else if (accept) begin
      pcount <= pcount_next;
      seqlen <= seqlen_next;
      cpos <= cpos_next;
      fdash <= fdash_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && start_seq) pend0 <= b;
    if (accept && wr_pend && pcount == 2'd1) pend1 <= b;
    if (accept && wr_pend && pcount == 2'd2) pend2 <= b;
  end

endmodule

// ===== rtl/cie_queue.sv =====
// command queue between front and back ends
module cie_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  cie_pkg::cmd_t wr_cmd,
  output logic          full,
  input  logic          rd,
  output logic          valid,
  output cie_pkg::cmd_t rd_cmd
);
  import cie_pkg::*;

  cmd_t           mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCW-1:0] count;
  logic           do_wr;
  logic           do_rd;

  assign full = (count == QCW'(QDEPTH));
  assign valid = (count != '0);
  assign rd_cmd = mem[rd_ptr];
  assign do_wr = wr && !full;
  assign do_rd = rd && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + QAW'(1);
      if (do_rd) rd_ptr <= rd_ptr + QAW'(1);
      if (do_wr && !do_rd) count <= count + QCW'(1);
      else if (do_rd && !do_wr) count <= count - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_cmd;
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCW'(QDEPTH)) else $error("queue count out of range");
  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    full && !do_rd |=> full) else $error("queue full dropped without read");
  a_empty_hold: assert property (@(posedge clk) disable iff (rst)
    !valid && !do_wr |=> !valid) else $error("queue filled without write");
`endif

endmodule

// ===== rtl/cie_back.sv =====
// back end: expands commands into output bytes, one beat per cycle while pop is high
module cie_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  cie_pkg::cmd_t       q_cmd,
  output logic                q_pop,
  input  logic                pop,
  output logic                empty,
  output cie_pkg::out_beat_t  result
);
  import cie_pkg::*;

  cmd_t       cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic [1:0] last_idx;
  logic       at_last;
  logic       load;
  logic [7:0] obyte;

  assign last_idx = 2'(cur.len - 3'd1);
  assign at_last = (idx == last_idx);
  assign load = q_valid && (!cur_valid || (pop && at_last));
  assign q_pop = load;
  assign empty = !cur_valid;

  always_comb begin
    obyte = CH_BSL;
    unique case (cur.op)
      OP_RAW: obyte = cur.bytes[idx];
      OP_REPL: begin
        unique case (idx)
          2'd0:    obyte = REPL_0;
          2'd1:    obyte = REPL_1;
          default: obyte = REPL_2;
        endcase
      end
      OP_BSL: obyte = (idx == 2'd0) ? CH_BSL : cur.bytes[0];
      OP_HEX: begin
        if (idx == 2'd0) obyte = CH_BSL;
        else if (idx == last_idx) obyte = CH_SPACE;
        else if (cur.len == 3'd4 && idx == 2'd1) obyte = hex_char(cur.bytes[0][7:4]);
        else obyte = hex_char(cur.bytes[0][3:0]);
      end
      default: obyte = CH_BSL;
    endcase
  end

  assign result.out_byte = obyte;
  assign result.out_last = cur.last && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx <= 2'd0;
    end else if (load) begin
      cur_valid <= 1'b1;
      idx <= 2'd0;
    end else if (pop && cur_valid) begin
      if (at_last) cur_valid <= 1'b0;
      else idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) cur <= q_cmd;
  end

`ifndef SYNTHESIS
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    cur_valid && !pop |=> cur_valid && $stable(idx)) else $error("beat changed under stall");
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> ({1'b0, idx} < cur.len)) else $error("byte index beyond command");
  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (cur.len != 3'd0)) else $error("empty command loaded");
`endif

endmodule

// ===== rtl/css_identifier_escaper.sv =====
// top level of the css identifier escaper
//
// input channel: push/full carries one utf-8 byte per beat with in_last on
// the final byte of the identifier; a beat is taken when push is high and
// full is low. result channel: empty/pop carries one serialized byte per
// beat with out_last on the final byte; the head beat is shown while empty
// is low and is taken when pop is high.
// the front end decodes and classifies each byte in the cycle it arrives and
// writes one command per character into a two-entry queue; the back end
// expands each command into one to four bytes, one per cycle while pop is high.
// the first byte of a character reaches the result ports through the queue
// entry and then the back end's current-command register. throughput: one
// input beat per cycle while each character yields a single byte and pop is
// high; an escape holds the back end until all of its bytes are taken.
// when the receiver stalls the queue fills and full rises, holding input.
// reset clears the decode state, the queue and the output stage; the block
// is ready the cycle after reset falls.
module css_identifier_escaper (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  cie_pkg::in_beat_t   item,
  output logic                empty,
  input  logic                pop,
  output cie_pkg::out_beat_t  result
);
  import cie_pkg::*;

  logic q_push;
  cmd_t q_wr_cmd;
  logic q_full;
  logic q_pop;
  logic q_valid;
  cmd_t q_rd_cmd;

  assign full = q_full;

  cie_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item   (item),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_wr_cmd)
  );

  cie_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (q_push),
    .wr_cmd (q_wr_cmd),
    .full   (q_full),
    .rd     (q_pop),
    .valid  (q_valid),
    .rd_cmd (q_rd_cmd)
  );

  cie_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_rd_cmd),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for the css identifier escaper with random stimulus and stalls
`timescale 1ns / 100ps

module tb_top;
  import cie_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_BEATS = 160;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_BANG = 8'h21;
  localparam logic [7:0] CH_LOWER_Z_ID = 8'h7A;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full;
  logic empty;
  in_beat_t item = '0;
  out_beat_t result;

  css_identifier_escaper uut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .item(item),
    .empty(empty),
    .pop(pop),
    .result(result)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  in_beat_t utf8_q[$];
  out_beat_t serial_q[$];
  logic [7:0] step_bytes[$];

  logic [7:0] gat_bytes[3];
  int gat_cnt = 0;
  int seq_len = 0;
  int char_pos = 0;
  bit first_dash = 1'b0;

  int beats_total = 0;
  int beats_sent = 0;
  int err_cnt = 0;
  int tx_idle = 0;
  int rx_hold = 0;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int idle_cyc = 0;

  function automatic logic [7:0] hex_nib(logic [3:0] v);
    return (v < 4'd10) ? CH_ZERO + 8'(v) : CH_LOWER_A + 8'(v) - 8'd10;
  endfunction

  function automatic int pick_gap(bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic put_hex(int unsigned cp);
    step_bytes.push_back(CH_BSL);
    if (cp >= 16) step_bytes.push_back(hex_nib(4'(cp >> 4)));
    step_bytes.push_back(hex_nib(4'(cp)));
    step_bytes.push_back(CH_SPACE);
  endtask

  task automatic put_char(int unsigned cp, logic [7:0] seq[4], int nb, bit alone);
    int nth;
    bit dig;
    nth = char_pos;
    dig = (cp >= CH_ZERO) && (cp <= CH_NINE);
    if (nth == 0) first_dash = (seq[0] == CH_DASH);
    if (cp == 0) begin
      step_bytes.push_back(REPL_0);
      step_bytes.push_back(REPL_1);
      step_bytes.push_back(REPL_2);
    end else if (cp <= CTRL_MAX || cp == CH_DEL) begin
      put_hex(cp);
    end else if (nth == 0 && dig) begin
      put_hex(cp);
    end else if (nth == 1 && dig && first_dash) begin
      put_hex(cp);
    end else if (nth == 0 && cp == CH_DASH && alone) begin
      step_bytes.push_back(CH_BSL);
      step_bytes.push_back(CH_DASH);
    end else if (cp >= 32'h80 || cp == CH_DASH || cp == CH_UNDER || dig ||
                 (cp >= CH_UPPER_A && cp <= CH_UPPER_Z) ||
                 (cp >= CH_LOWER_A && cp <= CH_LOWER_Z)) begin
      for (int i = 0; i < nb; i++) step_bytes.push_back(seq[i]);
    end else begin
      step_bytes.push_back(CH_BSL);
      step_bytes.push_back(8'(cp) & CH_DEL);
    end
    if (char_pos < 2) char_pos++;
  endtask

  task automatic escape_byte(logic [7:0] b, logic lst);
    logic [7:0] seq[4];
    int unsigned cp;
    int n;
    out_beat_t ob;
    step_bytes.delete();
    if (seq_len != 0) begin
      if (gat_cnt + 1 >= seq_len) begin
        n = seq_len;
        cp = (n == 2) ? (gat_bytes[0] & 8'h1F) :
             (n == 3) ? (gat_bytes[0] & 8'h0F) : (gat_bytes[0] & 8'h07);
        for (int i = 0; i < n - 1; i++) seq[i] = gat_bytes[i];
        seq[n - 1] = b;
        for (int i = 1; i < n; i++) cp = (cp << 6) | (seq[i] & 8'h3F);
        gat_cnt = 0;
        seq_len = 0;
        put_char(cp, seq, n, 1'b0);
      end else if (lst) begin
        for (int i = 0; i < gat_cnt; i++) step_bytes.push_back(gat_bytes[i]);
        step_bytes.push_back(b);
      end else begin
        gat_bytes[gat_cnt] = b;
        gat_cnt++;
      end
    end else if (b < 8'h80) begin
      seq[0] = b;
      put_char(b, seq, 1, lst && char_pos == 0);
    end else if (b < LEAD_MIN) begin
      if (char_pos == 0) first_dash = 1'b0;
      step_bytes.push_back(b);
      if (char_pos < 2) char_pos++;
    end else if (lst) begin
      step_bytes.push_back(b);
    end else begin
      gat_bytes[0] = b;
      gat_cnt = 1;
      seq_len = (b < 8'hE0) ? 2 : (b < 8'hF0) ? 3 : 4;
    end
    for (int i = 0; i < step_bytes.size(); i++) begin
      ob.out_byte = step_bytes[i];
      ob.out_last = lst && (i == step_bytes.size() - 1);
      serial_q.push_back(ob);
    end
    if (lst) begin
      gat_cnt = 0;
      seq_len = 0;
      char_pos = 0;
      first_dash = 1'b0;
    end
  endtask

  task automatic add_beat(logic [7:0] b, logic lst);
    in_beat_t t;
    t.in_byte = b;
    t.in_last = lst;
    utf8_q.push_back(t);
    beats_total++;
  endtask

  task automatic add_ident();
    int n_chars;
    int kind;
    int r;
    int nb;
    int keep;
    bit fin;
    logic [7:0] lead;
    n_chars = $urandom_range(1, 8);
    for (int c = 0; c < n_chars; c++) begin
      fin = (c == n_chars - 1);
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        r = $urandom_range(0, 9);
        if (r == 0) add_beat(CH_DASH, fin);
        else if (r == 1) add_beat(8'($urandom_range(CH_ZERO, CH_NINE)), fin);
        else if (r == 2) add_beat(($urandom_range(0, 3) == 0) ? CH_DEL :
                                  8'($urandom_range(0, CTRL_MAX)), fin);
        else add_beat(8'($urandom_range(0, 127)), fin);
      end else if (kind < 85) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          lead = 8'hE0;
        end else if (r < 18) begin
          lead = 8'($urandom_range(LEAD_MIN, 255));
        end else begin
          nb = $urandom_range(2, 4);
          lead = (nb == 2) ? 8'($urandom_range(LEAD_MIN, 8'hDF)) :
                 (nb == 3) ? 8'($urandom_range(8'hE0, 8'hEF)) :
                             8'($urandom_range(8'hF0, 8'hF4));
        end
        nb = (lead < 8'hE0) ? 2 : (lead < 8'hF0) ? 3 : 4;
        keep = (fin && $urandom_range(0, 5) == 0) ? $urandom_range(1, nb - 1) : nb;
        add_beat(lead, fin && keep == 1);
        for (int i = 1; i < keep; i++) begin
          if (r < 8 && i == 1) add_beat(8'h80, fin && i == keep - 1);
          else if ($urandom_range(0, 9) == 0) add_beat(8'($urandom_range(0, 255)),
                                                      fin && i == keep - 1);
          else add_beat(8'($urandom_range(8'h80, 8'hBF)), fin && i == keep - 1);
        end
      end else if (kind < 92) begin
        add_beat(8'($urandom_range(8'h80, LEAD_MIN - 1)), fin);
      end else begin
        add_beat(8'($urandom_range(0, 255)), fin);
      end
    end
  endtask

  always @(posedge clk) begin
    bit fired;
    fired = 1'b0;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        escape_byte(item.in_byte, item.in_last);
        beats_sent++;
        fired = 1'b1;
      end
      if (!push || fired) begin
        if (tx_idle != 0) begin
          tx_idle--;
          push <= 1'b0;
        end else if (utf8_q.size() > 0) begin
          item <= utf8_q.pop_front();
          push <= 1'b1;
          if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
          tx_idle = pick_gap(tx_steady);
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_beat_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (serial_q.size() == 0) begin
          if (err_cnt < 10)
            $display("unexpected beat: byte %h last %b", result.out_byte, result.out_last);
          err_cnt++;
        end else begin
          want = serial_q.pop_front();
          if (result.out_byte !== want.out_byte || result.out_last !== want.out_last) begin
            if (err_cnt < 10)
              $display("mismatch: expected byte %h last %b, got byte %h last %b",
                       want.out_byte, want.out_last, result.out_byte, result.out_last);
            err_cnt++;
          end
        end
        if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
        rx_hold = pick_gap(rx_steady);
      end
      if (rx_hold != 0) begin
        rx_hold--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cyc <= 0;
    end else if (idle_cyc >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

  initial begin
    // lone dash, nul, leading digit, digit after leading dash
    add_beat(CH_DASH, 1'b1);
    add_beat(8'h00, 1'b1);
    add_beat(8'h31, 1'b0);
    add_beat(CH_LOWER_A, 1'b1);
    add_beat(CH_DASH, 1'b0);
    add_beat(8'h35, 1'b1);
    // control, del, punctuation
    add_beat(8'h01, 1'b0);
    add_beat(CH_DEL, 1'b0);
    add_beat(CH_BANG, 1'b1);
    // stray bytes
    add_beat(8'h80, 1'b0);
    add_beat(8'hC1, 1'b0);
    add_beat(CH_LOWER_Z_ID, 1'b1);
    // two byte sequence, overlong nul
    add_beat(8'hC3, 1'b0);
    add_beat(8'hA9, 1'b1);
    add_beat(8'hE0, 1'b0);
    add_beat(8'h80, 1'b0);
    add_beat(8'h80, 1'b1);
    // four byte sequence then a cut one
    add_beat(8'hF0, 1'b0);
    add_beat(8'h9F, 1'b0);
    add_beat(8'h98, 1'b0);
    add_beat(8'h80, 1'b0);
    add_beat(8'hFF, 1'b0);
    add_beat(CH_UPPER_A, 1'b1);
    // lead byte as the whole identifier
    add_beat(8'hE2, 1'b1);
    while (beats_total < 24 + RANDOM_BEATS) add_ident();

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    wait (beats_sent == beats_total);
    wait (serial_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0 && serial_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/cie_pkg.sv
rtl/cie_front.sv
rtl/cie_queue.sv
rtl/cie_back.sv
rtl/css_identifier_escaper.sv
tb/sv/tb_top.sv
